>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define CHK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define CHK_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/tach_pkg.sv
// Package: widths, register map and reset values of the tachometer.
`timescale 1ns / 1ps
package tach_pkg;

    localparam int NUM_W   = 24;   // rate numerator width
    localparam int PER_W   = 16;   // period field width
    localparam int SPD_W   = 10;   // speed width
    localparam int DIG_W   = 4;    // one decimal digit
    localparam int CNT_W   = 2;    // digit count width
    localparam int DATA_W  = 32;   // APB data width

    typedef logic [DIG_W-1:0] t_digit;
    typedef logic [SPD_W-1:0] t_speed;

    localparam logic [NUM_W-1:0] RATE_RESET  = 24'd468720;
    localparam t_speed           LIMIT_RESET = 10'd999;
    localparam t_speed           LIMIT_MAX   = 10'd999;
    localparam t_speed           LAST_RESET  = 10'd1;

    // register index, taken from paddr bit 2
    localparam logic REG_RATE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    localparam logic [CNT_W-1:0] DCNT_ONE   = 2'd1;
    localparam logic [CNT_W-1:0] DCNT_TWO   = 2'd2;
    localparam logic [CNT_W-1:0] DCNT_THREE = 2'd3;

endpackage

>>> rtl/tachometer_rpm_from_period_top.sv
// Top level: period-to-speed tachometer with bit-serial divider and digit split.
`timescale 1ns / 1ps
// Turns one request (a captured period, or a no-rotation timeout) into one speed
// result: rate_numerator / period, clamped to min(speed_limit, 999), zero for a
// timeout or a zero period, split into three decimal digits with a significant
// digit count and changed/saturated flags. One request at a time: a period goes through
// an accept step, the restoring divider (one quotient bit per cycle), a clamp step,
// serial binary-to-BCD conversion and a load of the output register once it is free;
// a timeout or zero period skips the divider. The next request is taken as soon as
// the result sits in the output register, even if the consumer has not yet taken it.
module tachometer_rpm_from_period_top
    import tach_pkg::*;
#(
    parameter int PERIOD_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_command,
    input  logic [PER_W-1:0]  i_period,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [SPD_W-1:0]  o_speed,
    output logic [DIG_W-1:0]  o_hundreds,
    output logic [DIG_W-1:0]  o_tens,
    output logic [DIG_W-1:0]  o_units,
    output logic [CNT_W-1:0]  o_digit_count,
    output logic              o_changed,
    output logic              o_saturated,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:2]        paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int KEEP_W = (PERIOD_BITS < PER_W) ? PERIOD_BITS : PER_W;
    localparam logic [PER_W-1:0] PMASK = PER_W'((33'd1 << KEEP_W) - 33'd1);
    localparam int SEQ_W = $clog2(NUM_W);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_CLAMP = 3'd2;
    localparam logic [2:0] S_BCD   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [SEQ_W-1:0]  r_seq, n_seq;
    logic [NUM_W-1:0]  r_rate;
    t_speed            r_limit;
    t_speed            r_last, n_last;
    logic [PER_W-1:0]  r_div, n_div;
    logic [PER_W-1:0]  r_rem, n_rem;
    logic [NUM_W-1:0]  r_num, n_num;
    logic              r_zero, n_zero;
    t_speed            r_speed, n_speed;
    logic              r_sat, n_sat;
    t_speed            r_bin, n_bin;
    logic [3*DIG_W-1:0] r_bcd, n_bcd;

    logic              r_ov, n_ov;
    t_speed            r_o_speed, n_o_speed;
    t_digit            r_o_h, n_o_h, r_o_t, n_o_t, r_o_u, n_o_u;
    logic [CNT_W-1:0]  r_o_cnt, n_o_cnt;
    logic              r_o_chg, n_o_chg, r_o_sat, n_o_sat;

    logic [PER_W-1:0]  per_in;
    logic [PER_W:0]    trial, diff;
    logic              ge;
    t_speed            lim;
    logic [3*DIG_W-1:0] adj;
    logic              slot_free;
    logic              cfg_wr;

    assign per_in = i_period & PMASK;
    assign trial  = {r_rem, r_num[NUM_W-1]};
    assign diff   = trial - {1'b0, r_div};
    assign ge     = (trial >= {1'b0, r_div});
    assign lim    = (r_limit > LIMIT_MAX) ? LIMIT_MAX : r_limit;
    assign slot_free = !r_ov || i_out_ready;

    // add-3 on every BCD digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            adj[k*DIG_W +: DIG_W] = (r_bcd[k*DIG_W +: DIG_W] >= DIG_W'(5))
                ? r_bcd[k*DIG_W +: DIG_W] + DIG_W'(3)
                : r_bcd[k*DIG_W +: DIG_W];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_seq     = r_seq;
        n_last    = r_last;
        n_div     = r_div;
        n_rem     = r_rem;
        n_num     = r_num;
        n_zero    = r_zero;
        n_speed   = r_speed;
        n_sat     = r_sat;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_ov      = r_ov && !i_out_ready;
        n_o_speed = r_o_speed;
        n_o_h     = r_o_h;
        n_o_t     = r_o_t;
        n_o_u     = r_o_u;
        n_o_cnt   = r_o_cnt;
        n_o_chg   = r_o_chg;
        n_o_sat   = r_o_sat;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_div  = per_in;
                    n_num  = r_rate;
                    n_rem  = '0;
                    n_seq  = '0;
                    n_zero = i_command || (per_in == '0);
                    n_state = (i_command || (per_in == '0)) ? S_CLAMP : S_DIV;
                end
            end
            S_DIV: begin
                n_rem = ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
                n_num = {r_num[NUM_W-2:0], ge};
                n_seq = r_seq + 1'b1;
                if (r_seq == SEQ_W'(NUM_W - 1)) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                // clamp on the full quotient
                if (r_zero) begin
                    n_speed = '0;
                    n_sat   = 1'b0;
                end else if (r_num > NUM_W'(lim)) begin
                    n_speed = lim;
                    n_sat   = 1'b1;
                end else begin
                    n_speed = r_num[SPD_W-1:0];
                    n_sat   = 1'b0;
                end
                n_bin   = n_speed;
                n_bcd   = '0;
                n_seq   = '0;
                n_state = S_BCD;
            end
            S_BCD: begin
                n_bcd = {adj[3*DIG_W-2:0], r_bin[SPD_W-1]};
                n_bin = {r_bin[SPD_W-2:0], 1'b0};
                n_seq = r_seq + 1'b1;
                if (r_seq == SEQ_W'(SPD_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    n_ov      = 1'b1;
                    n_o_speed = r_speed;
                    n_o_h     = r_bcd[2*DIG_W +: DIG_W];
                    n_o_t     = r_bcd[DIG_W +: DIG_W];
                    n_o_u     = r_bcd[0 +: DIG_W];
                    if (r_bcd[2*DIG_W +: DIG_W] != '0) begin
                        n_o_cnt = DCNT_THREE;
                    end else if (r_bcd[DIG_W +: DIG_W] != '0) begin
                        n_o_cnt = DCNT_TWO;
                    end else begin
                        n_o_cnt = DCNT_ONE;
                    end
                    n_o_chg = (r_speed != r_last);
                    n_o_sat = r_sat;
                    n_last  = r_speed;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_last  <= LAST_RESET;
            r_rate  <= RATE_RESET;
            r_limit <= LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_last  <= n_last;
            if (cfg_wr && paddr[2] == REG_RATE) begin
                r_rate <= pwdata[NUM_W-1:0];
            end
            if (cfg_wr && paddr[2] == REG_LIMIT) begin
                r_limit <= pwdata[SPD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq     <= n_seq;
        r_div     <= n_div;
        r_rem     <= n_rem;
        r_num     <= n_num;
        r_zero    <= n_zero;
        r_speed   <= n_speed;
        r_sat     <= n_sat;
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_o_speed <= n_o_speed;
        r_o_h     <= n_o_h;
        r_o_t     <= n_o_t;
        r_o_u     <= n_o_u;
        r_o_cnt   <= n_o_cnt;
        r_o_chg   <= n_o_chg;
        r_o_sat   <= n_o_sat;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_ov;
    assign o_speed       = r_o_speed;
    assign o_hundreds    = r_o_h;
    assign o_tens        = r_o_t;
    assign o_units       = r_o_u;
    assign o_digit_count = r_o_cnt;
    assign o_changed     = r_o_chg;
    assign o_saturated   = r_o_sat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RATE) ? DATA_W'(r_rate) : DATA_W'(r_limit);

endmodule

>>> rtl/tach_chk.sv
// Port-level checker for the tachometer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tach_chk
    import tach_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [SPD_W-1:0] o_speed,
    input logic [DIG_W-1:0] o_hundreds,
    input logic [DIG_W-1:0] o_tens,
    input logic [DIG_W-1:0] o_units,
    input logic [CNT_W-1:0] o_digit_count,
    input logic             o_saturated
);

    logic [SPD_W-1:0] digit_sum;
    logic             digits_ok;
    logic             count_ok;

    assign digit_sum = SPD_W'(o_hundreds) * SPD_W'(100) + SPD_W'(o_tens) * SPD_W'(10)
                     + SPD_W'(o_units);
    assign digits_ok = (o_hundreds <= 4'd9) && (o_tens <= 4'd9) && (o_units <= 4'd9)
                     && (digit_sum == o_speed);
    assign count_ok  = ((o_hundreds != '0) && (o_digit_count == DCNT_THREE))
                     || ((o_hundreds == '0) && (o_tens != '0) && (o_digit_count == DCNT_TWO))
                     || ((o_hundreds == '0) && (o_tens == '0) && (o_digit_count == DCNT_ONE));

    // digits rebuild the speed
    `CHK_IMP(a_digits, o_out_valid, digits_ok)

    // leading-zero count agrees with the digits
    `CHK_IMP(a_count, o_out_valid, count_ok)

    // speed never leaves the display range
    `CHK_IMP(a_range, o_out_valid, o_speed <= LIMIT_MAX)

    // a stalled result holds
    `CHK_NXT(a_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_speed) && $stable(o_saturated))

endmodule

bind tachometer_rpm_from_period_top tach_chk u_tach_chk (.*);
